// File: hw/rtl/dahp_pkg.sv
// ----------------------------------------------------------------------------
// Digest header parser package
// Shared types and constants for the digest authenticate header parser.
// ----------------------------------------------------------------------------
package dahp_pkg;

   typedef enum logic [7:0] {
      PH_PREFIX   = 8'b0000_0001,
      PH_SKIP     = 8'b0000_0010,
      PH_KEY      = 8'b0000_0100,
      PH_VALSTART = 8'b0000_1000,
      PH_QUOTED   = 8'b0001_0000,
      PH_UNQUOTED = 8'b0010_0000,
      PH_DROP     = 8'b0100_0000,
      PH_DONE     = 8'b1000_0000
   } phase_type;

   localparam int unsigned PREFIX_BYTES = 7;
   localparam int unsigned NUM_KEYS     = 5;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam int unsigned K_NONCE  = 0;
   localparam int unsigned K_REALM  = 1;
   localparam int unsigned K_QOP    = 2;
   localparam int unsigned K_OPAQUE = 3;
   localparam int unsigned K_ALGO   = 4;

   typedef struct packed {
      logic        found;
      logic [15:0] start;
      logic [16:0] length;
   } field_rec_type;

   function automatic logic [3:0] key_len(input int unsigned k);
      case (k)
         K_NONCE:  key_len = 4'd6;
         K_REALM:  key_len = 4'd6;
         K_QOP:    key_len = 4'd4;
         K_OPAQUE: key_len = 4'd7;
         default:  key_len = 4'd10;
      endcase
   endfunction

   function automatic logic [7:0] key_char(input int unsigned k, input logic [3:0] p);
      logic [79:0] s;
      s = 80'h0;
      case (k)
         K_NONCE:  s = {"nonce=", 32'h0};
         K_REALM:  s = {"realm=", 32'h0};
         K_QOP:    s = {"qop=", 48'h0};
         K_OPAQUE: s = {"opaque=", 24'h0};
         default:  s = "algorithm=";
      endcase
      key_char = (p < 4'd10) ? s[8'(79 - 8 * int'(p)) -: 8] : 8'h00;
   endfunction

   function automatic logic [7:0] authint_char(input logic [3:0] p);
      logic [63:0] s;
      s = "auth-int";
      authint_char = (p < 4'd8) ? s[7'(63 - 8 * int'(p)) -: 8] : 8'h00;
   endfunction

   function automatic logic [7:0] md5_char(input logic [3:0] p);
      logic [23:0] s;
      s = "MD5";
      md5_char = (p < 4'd3) ? s[5'(23 - 8 * int'(p)) -: 8] : 8'h00;
   endfunction

endpackage

// File: hw/rtl/digest_auth_header_parser.sv
// ----------------------------------------------------------------------------
// Digest authenticate header parser
// Parses one header value per frame of bytes and reports field locations.
// ----------------------------------------------------------------------------
// The block takes one header byte per transfer and accepts a byte in every
// cycle that no held result blocks; each accepted byte updates the parser
// state. On the transfer marked last, one result leaves through an output
// register in the next cycle, and the parser is already cleared for the next
// header. Input stalls only while a finished result waits and cannot be moved on.
module digest_auth_header_parser #(
   parameter int unsigned MAX_TOKENS       = 12,
   parameter int unsigned MAX_HEADER_BYTES = 1024,
   parameter int unsigned MAX_QOP_OPTIONS  = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_nonce_found,
   output logic [9:0]  rsp_nonce_start,
   output logic [10:0] rsp_nonce_length,
   output logic        rsp_realm_found,
   output logic [9:0]  rsp_realm_start,
   output logic [10:0] rsp_realm_length,
   output logic        rsp_opaque_found,
   output logic [9:0]  rsp_opaque_start,
   output logic [10:0] rsp_opaque_length,
   output logic [1:0]  rsp_qop_flags,
   output logic        rsp_algorithm_md5,
   output logic [3:0]  rsp_token_count
);
   import dahp_pkg::*;

   localparam int PW = $clog2(MAX_HEADER_BYTES + 1);
   localparam int TW = $clog2(MAX_TOKENS + 1);
   localparam int OW = $clog2(MAX_QOP_OPTIONS + 1);

   phase_type          phase_ff, phase_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [TW-1:0]      tok_ff, tok_in;
   logic [4:0]         cand_ff, cand_in;
   logic [3:0]         kpos_ff, kpos_in;
   logic [15:0]        vstart_ff, vstart_in;
   logic [3:0]         opos_ff, opos_in;
   logic               ofrz_ff, ofrz_in;
   logic               oin_ff, oin_in;
   logic [OW-1:0]      onum_ff, onum_in;
   logic [1:0]         opend_ff, opend_in;
   field_rec_type      rec_ff [3];
   field_rec_type      rec_in [3];
   logic [1:0]         qop_ff, qop_in;
   logic               md5_ff, md5_in;

   logic               ov_ff;
   field_rec_type      orec_ff [3];
   logic [1:0]         oqop_ff;
   logic               omd5_ff;
   logic [3:0]         otok_ff;

   logic               acc;
   logic [15:0]        pos16;
   logic [2:0]         ckey;
   field_rec_type      frec [3];
   logic [1:0]         fqop;
   logic               fmd5;

   assign req_ready = !ov_ff || rsp_ready;
   assign acc       = req_valid && req_ready;
   assign pos16     = 16'(pos_ff);

   always_comb begin
      ckey = 3'd5;
      for (int k = NUM_KEYS - 1; k >= 0; k--) begin
         if (cand_in[k]) begin
            ckey = 3'(k);
         end
      end
   end

   always_comb begin
      logic [7:0]  b;
      logic        active;
      logic        nul;
      logic        do_val;
      logic        do_commit;
      logic [15:0] cend;
      logic        do_fin;
      logic [1:0]  pend;
      logic [4:0]  sel;
      int          ri;

      b         = req_data_byte;
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      tok_in    = tok_ff;
      cand_in   = cand_ff;
      kpos_in   = kpos_ff;
      vstart_in = vstart_ff;
      opos_in   = opos_ff;
      ofrz_in   = ofrz_ff;
      oin_in    = oin_ff;
      onum_in   = onum_ff;
      opend_in  = opend_ff;
      qop_in    = qop_ff;
      md5_in    = md5_ff;
      for (int i = 0; i < 3; i++) begin
         rec_in[i] = rec_ff[i];
      end
      do_val    = 1'b0;
      do_commit = 1'b0;
      cend      = pos16;
      sel       = 5'd0;
      ri        = 0;

      active = (32'(pos_ff) < MAX_HEADER_BYTES);
      nul    = (b == CH_NUL);
      do_fin = 1'b0;

      if (active) begin
         pos_in = pos_ff + PW'(1);
         if (phase_ff != PH_DONE) begin
            if (nul) begin
               do_fin = 1'b1;
            end else begin
               case (phase_ff)
                  PH_PREFIX: begin
                     if (32'(pos_ff) + 1 >= PREFIX_BYTES) begin
                        phase_in = PH_SKIP;
                     end
                  end
                  PH_SKIP, PH_KEY: begin
                     if (phase_ff == PH_SKIP && (b == CH_SPACE || b == CH_COMMA)) begin
                        phase_in = PH_SKIP;
                     end else if (phase_ff == PH_SKIP && 32'(tok_ff) >= MAX_TOKENS) begin
                        phase_in = PH_DONE;
                     end else begin
                        logic [4:0] c;
                        logic [3:0] kp;
                        c  = cand_ff;
                        kp = kpos_ff;
                        if (phase_ff == PH_SKIP) begin
                           tok_in = tok_ff + TW'(1);
                           c      = 5'h1F;
                           kp     = 4'd0;
                        end
                        phase_in = PH_KEY;
                        if (b == CH_EQUAL) begin
                           for (int k = 0; k < NUM_KEYS; k++) begin
                              if (c[k] && (5'(kp) + 5'd1 == 5'(key_len(k)))) begin
                                 sel = 5'(1 << k);
                              end
                           end
                           cand_in   = sel;
                           kpos_in   = kp;
                           vstart_in = pos16 + 16'd1;
                           opos_in   = 4'd0;
                           ofrz_in   = 1'b0;
                           oin_in    = 1'b0;
                           onum_in   = '0;
                           opend_in  = 2'd0;
                           phase_in  = PH_VALSTART;
                        end else begin
                           for (int k = 0; k < NUM_KEYS; k++) begin
                              if (c[k] && !((5'(kp) + 5'd1 < 5'(key_len(k))) &&
                                            key_char(k, kp) == b)) begin
                                 c[k] = 1'b0;
                              end
                           end
                           cand_in = c;
                           kpos_in = (kp < 4'd15) ? kp + 4'd1 : kp;
                        end
                     end
                  end
                  PH_VALSTART, PH_UNQUOTED: begin
                     if (phase_ff == PH_VALSTART && b == CH_QUOTE) begin
                        vstart_in = pos16 + 16'd1;
                        phase_in  = PH_QUOTED;
                     end else begin
                        if (phase_ff == PH_VALSTART) begin
                           vstart_in = pos16;
                        end
                        phase_in = PH_UNQUOTED;
                        if (b == CH_COMMA) begin
                           do_commit = 1'b1;
                           phase_in  = PH_SKIP;
                        end else begin
                           do_val = 1'b1;
                        end
                     end
                  end
                  PH_QUOTED: begin
                     if (b == CH_QUOTE) begin
                        do_commit = 1'b1;
                        phase_in  = PH_DROP;
                     end else begin
                        do_val = 1'b1;
                     end
                  end
                  PH_DROP: begin
                     phase_in = PH_SKIP;
                  end
                  default: begin
                  end
               endcase
            end
         end
      end

      if (req_last && phase_ff != PH_DONE && !(active && nul)) begin
         do_fin = 1'b1;
      end
      if (do_fin) begin
         if (phase_in == PH_VALSTART || phase_in == PH_UNQUOTED) begin
            do_commit = 1'b1;
            cend      = 16'(pos_in);
         end else if (phase_in == PH_QUOTED) begin
            if (ckey == 3'(K_NONCE) || ckey == 3'(K_REALM) || ckey == 3'(K_OPAQUE)) begin
               ri = (ckey == 3'(K_NONCE)) ? 0 : (ckey == 3'(K_REALM)) ? 1 : 2;
               rec_in[ri] = '0;
            end
         end
         if (do_fin && active && nul) begin
            cend = pos16;
         end
      end

      if (do_val) begin
         if (ckey == 3'(K_ALGO)) begin
            if (!ofrz_in && opos_in < 4'd3) begin
               if (md5_char(opos_in) == b) opos_in = opos_in + 4'd1;
               else ofrz_in = 1'b1;
            end
         end else if (ckey == 3'(K_QOP)) begin
            if (oin_in) begin
               if (b == CH_COMMA) begin
                  if (opos_in >= 4'd8) opend_in[1] = 1'b1;
                  else if (opos_in >= 4'd4) opend_in[0] = 1'b1;
                  oin_in = 1'b0;
               end else if (!ofrz_in && opos_in < 4'd8) begin
                  if (authint_char(opos_in) == b) opos_in = opos_in + 4'd1;
                  else ofrz_in = 1'b1;
               end
            end else if (b != CH_SPACE && b != CH_COMMA &&
                         32'(onum_in) < MAX_QOP_OPTIONS) begin
               onum_in = onum_in + OW'(1);
               oin_in  = 1'b1;
               ofrz_in = 1'b0;
               opos_in = (authint_char(4'd0) == b) ? 4'd1 : 4'd0;
               ofrz_in = (authint_char(4'd0) != b);
            end
         end
      end

      if (do_commit) begin
         if (ckey == 3'(K_NONCE) || ckey == 3'(K_REALM) || ckey == 3'(K_OPAQUE)) begin
            ri = (ckey == 3'(K_NONCE)) ? 0 : (ckey == 3'(K_REALM)) ? 1 : 2;
            rec_in[ri].found  = 1'b1;
            rec_in[ri].start  = vstart_in;
            rec_in[ri].length = 17'(cend - vstart_in);
         end else if (ckey == 3'(K_QOP)) begin
            pend = opend_in;
            if (oin_in) begin
               if (opos_in >= 4'd8) pend[1] = 1'b1;
               else if (opos_in >= 4'd4) pend[0] = 1'b1;
               oin_in = 1'b0;
            end
            opend_in = pend;
            qop_in   = qop_in | pend;
         end else if (ckey == 3'(K_ALGO)) begin
            if (opos_in >= 4'd3) md5_in = 1'b1;
         end
      end
      if (do_fin) begin
         phase_in = PH_DONE;
      end

      for (int i = 0; i < 3; i++) begin
         frec[i] = rec_in[i];
      end
      fqop = qop_in;
      fmd5 = md5_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (acc && req_last) begin
         ov_ff <= 1'b1;
      end else if (rsp_ready) begin
         ov_ff <= 1'b0;
      end
      if (acc && req_last) begin
         for (int i = 0; i < 3; i++) begin
            orec_ff[i] <= frec[i];
         end
         oqop_ff <= fqop;
         omd5_ff <= fmd5;
         otok_ff <= 4'(tok_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (acc && req_last)) begin
         phase_ff  <= PH_PREFIX;
         pos_ff    <= '0;
         tok_ff    <= '0;
         cand_ff   <= 5'h1F;
         kpos_ff   <= 4'd0;
         vstart_ff <= 16'd0;
         opos_ff   <= 4'd0;
         ofrz_ff   <= 1'b0;
         oin_ff    <= 1'b0;
         onum_ff   <= '0;
         opend_ff  <= 2'd0;
         qop_ff    <= 2'd0;
         md5_ff    <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            rec_ff[i] <= '0;
         end
      end else if (acc) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         tok_ff    <= tok_in;
         cand_ff   <= cand_in;
         kpos_ff   <= kpos_in;
         vstart_ff <= vstart_in;
         opos_ff   <= opos_in;
         ofrz_ff   <= ofrz_in;
         oin_ff    <= oin_in;
         onum_ff   <= onum_in;
         opend_ff  <= opend_in;
         qop_ff    <= qop_in;
         md5_ff    <= md5_in;
         for (int i = 0; i < 3; i++) begin
            rec_ff[i] <= rec_in[i];
         end
      end
   end

   assign rsp_valid         = ov_ff;
   assign rsp_nonce_found   = orec_ff[0].found;
   assign rsp_nonce_start   = orec_ff[0].start[9:0];
   assign rsp_nonce_length  = orec_ff[0].length[10:0];
   assign rsp_realm_found   = orec_ff[1].found;
   assign rsp_realm_start   = orec_ff[1].start[9:0];
   assign rsp_realm_length  = orec_ff[1].length[10:0];
   assign rsp_opaque_found  = orec_ff[2].found;
   assign rsp_opaque_start  = orec_ff[2].start[9:0];
   assign rsp_opaque_length = orec_ff[2].length[10:0];
   assign rsp_qop_flags     = oqop_ff;
   assign rsp_algorithm_md5 = omd5_ff;
   assign rsp_token_count   = otok_ff;

endmodule

// File: bench/tb_digest_auth_header_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Digest authenticate header parser testbench
// Sends header values byte by byte, predicts the field locations and flags
// of each header and compares every result transfer with its prediction as a whole.
// ----------------------------------------------------------------------------
module tb_digest_auth_header_parser;
   import dahp_pkg::*;

   localparam int MAX_TOK = 12;
   localparam int MAX_BYTES = 1024;
   localparam int MAX_QOP = 2;

   typedef struct packed {
      logic        nonce_found;
      logic [9:0]  nonce_start;
      logic [10:0] nonce_length;
      logic        realm_found;
      logic [9:0]  realm_start;
      logic [10:0] realm_length;
      logic        opaque_found;
      logic [9:0]  opaque_start;
      logic [10:0] opaque_length;
      logic [1:0]  qop_flags;
      logic        algorithm_md5;
      logic [3:0]  token_count;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   result_type  got;

   result_type  expected_q[$];
   int          errors = 0;
   bit          idle_on = 1'b1;
   int          hold_cycles = 0;

   // Predictor state.
   phase_type   ph;
   int          pos, toks, cand, kpos, vstart;
   int          opos, ofrozen, oin, oopts, opend;
   int          ffound[3], fstart[3], flen[3];
   int          qbits, md5;

   always #10 clock = ~clock;

   digest_auth_header_parser u_top (
      .clock, .reset, .req_valid, .req_ready, .req_data_byte, .req_last,
      .rsp_valid, .rsp_ready,
      .rsp_nonce_found(got.nonce_found), .rsp_nonce_start(got.nonce_start),
      .rsp_nonce_length(got.nonce_length), .rsp_realm_found(got.realm_found),
      .rsp_realm_start(got.realm_start), .rsp_realm_length(got.realm_length),
      .rsp_opaque_found(got.opaque_found), .rsp_opaque_start(got.opaque_start),
      .rsp_opaque_length(got.opaque_length), .rsp_qop_flags(got.qop_flags),
      .rsp_algorithm_md5(got.algorithm_md5), .rsp_token_count(got.token_count)
   );

   function automatic string key_str(int k);
      case (k)
         K_NONCE:  return "nonce=";
         K_REALM:  return "realm=";
         K_QOP:    return "qop=";
         K_OPAQUE: return "opaque=";
         default:  return "algorithm=";
      endcase
   endfunction

   function automatic int rec_of(int k);
      return (k == K_NONCE) ? 0 : (k == K_REALM) ? 1 : 2;
   endfunction

   function automatic void parser_clear();
      ph = PH_PREFIX;
      pos = 0; toks = 0; cand = 5'h1F; kpos = 0; vstart = 0;
      opos = 0; ofrozen = 0; oin = 0; oopts = 0; opend = 0;
      for (int i = 0; i < 3; i++) begin
         ffound[i] = 0; fstart[i] = 0; flen[i] = 0;
      end
      qbits = 0; md5 = 0;
   endfunction

   function automatic int active_key();
      for (int k = 0; k < NUM_KEYS; k++)
         if (cand[k]) return k;
      return NUM_KEYS;
   endfunction

   function automatic void opt_match(string s, int b);
      if (!ofrozen && opos < s.len()) begin
         if (s[opos] == b) opos++;
         else ofrozen = 1;
      end
   endfunction

   function automatic void opt_close();
      if (oin) begin
         if (opos >= 8) opend |= 2;
         else if (opos >= 4) opend |= 1;
         oin = 0;
      end
   endfunction

   function automatic void value_char(int b);
      int k;
      k = active_key();
      if (k == K_ALGO) opt_match("MD5", b);
      else if (k == K_QOP) begin
         if (oin) begin
            if (b == CH_COMMA) opt_close();
            else opt_match("auth-int", b);
         end else if (b != CH_SPACE && b != CH_COMMA && oopts < MAX_QOP) begin
            oopts++; oin = 1; opos = 0; ofrozen = 0;
            opt_match("auth-int", b);
         end
      end
   endfunction

   function automatic void commit(int stop);
      int k;
      k = active_key();
      if (k == K_NONCE || k == K_REALM || k == K_OPAQUE) begin
         ffound[rec_of(k)] = 1;
         fstart[rec_of(k)] = vstart;
         flen[rec_of(k)] = stop - vstart;
      end else if (k == K_QOP) begin
         opt_close();
         qbits |= opend & 3;
      end else if (k == K_ALGO) begin
         if (opos >= 3) md5 = 1;
      end
   endfunction

   function automatic void wrap_up();
      int k;
      if (ph == PH_VALSTART || ph == PH_UNQUOTED) commit(pos);
      else if (ph == PH_QUOTED) begin
         k = active_key();
         if (k == K_NONCE || k == K_REALM || k == K_OPAQUE) begin
            ffound[rec_of(k)] = 0; fstart[rec_of(k)] = 0; flen[rec_of(k)] = 0;
         end
      end
      ph = PH_DONE;
   endfunction

   function automatic void key_char_step(int b);
      int sel;
      string s;
      sel = 0;
      if (b == CH_EQUAL) begin
         for (int k = 0; k < NUM_KEYS; k++) begin
            s = key_str(k);
            if (cand[k] && kpos + 1 == s.len()) sel = 1 << k;
         end
         cand = sel;
         vstart = pos + 1;
         opos = 0; ofrozen = 0; oin = 0; oopts = 0; opend = 0;
         ph = PH_VALSTART;
         return;
      end
      for (int k = 0; k < NUM_KEYS; k++) begin
         s = key_str(k);
         if (cand[k] && !(kpos + 1 < s.len() && s[kpos] == b)) cand &= ~(1 << k);
      end
      if (kpos < 15) kpos++;
   endfunction

   function automatic void parse_char(int b);
      if (b == 0) begin
         wrap_up();
         return;
      end
      case (ph)
         PH_PREFIX: if (pos + 1 >= PREFIX_BYTES) ph = PH_SKIP;
         PH_SKIP: begin
            if (b != CH_SPACE && b != CH_COMMA) begin
               if (toks >= MAX_TOK) ph = PH_DONE;
               else begin
                  toks++; cand = 5'h1F; kpos = 0; ph = PH_KEY;
                  key_char_step(b);
               end
            end
         end
         PH_KEY: key_char_step(b);
         PH_VALSTART: begin
            if (b == CH_QUOTE) begin
               vstart = pos + 1; ph = PH_QUOTED;
            end else begin
               ph = PH_UNQUOTED; vstart = pos;
               if (b == CH_COMMA) begin
                  commit(pos); ph = PH_SKIP;
               end else value_char(b);
            end
         end
         PH_UNQUOTED: begin
            if (b == CH_COMMA) begin
               commit(pos); ph = PH_SKIP;
            end else value_char(b);
         end
         PH_QUOTED: begin
            if (b == CH_QUOTE) begin
               commit(pos); ph = PH_DROP;
            end else value_char(b);
         end
         PH_DROP: ph = PH_SKIP;
         default: ;
      endcase
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic lst);
      result_type e;
      if (pos < MAX_BYTES) begin
         if (ph != PH_DONE) parse_char(int'(b));
         pos++;
      end
      if (lst) begin
         if (ph != PH_DONE) wrap_up();
         e.nonce_found = 1'(ffound[0]);
         e.nonce_start = 10'(fstart[0]);
         e.nonce_length = 11'(flen[0]);
         e.realm_found = 1'(ffound[1]);
         e.realm_start = 10'(fstart[1]);
         e.realm_length = 11'(flen[1]);
         e.opaque_found = 1'(ffound[2]);
         e.opaque_start = 10'(fstart[2]);
         e.opaque_length = 11'(flen[2]);
         e.qop_flags = 2'(qbits);
         e.algorithm_md5 = 1'(md5);
         e.token_count = 4'(toks);
         expected_q.push_back(e);
         parser_clear();
      end
   endfunction

   task automatic send_byte(logic [7:0] b, logic lst);
      if (idle_on && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (idle_on && $urandom_range(99) < 33);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_byte(b, lst);
   endtask

   task automatic send_part(string s, bit lst_at_end);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], lst_at_end && (i == s.len() - 1));
   endtask

   task automatic send_header(string s);
      send_part(s, 1'b1);
   endtask

   function automatic string rand_text(int n);
      string s;
      byte c;
      s = "";
      for (int i = 0; i < n; i++) begin
         c = 8'($urandom_range(33, 126));
         if (c == CH_QUOTE || c == CH_COMMA || c == CH_EQUAL) c = "x";
         s = $sformatf("%s%c", s, c);
      end
      return s;
   endfunction

   function automatic string rand_token();
      string v;
      int r;
      r = $urandom_range(9);
      case ($urandom_range(6))
         0: v = "auth";
         1: v = "auth-int";
         2: v = "MD5";
         3: v = "auth,auth-int";
         4: v = "auth-int,auth,auth";
         default: v = rand_text($urandom_range(0, 12));
      endcase
      if (r < 6) v = {"\"", v, "\""};
      case ($urandom_range(7))
         0: return {"nonce=", v};
         1: return {"realm=", v};
         2: return {"qop=", v};
         3: return {"opaque=", v};
         4: return {"algorithm=", v};
         5: return {rand_text($urandom_range(1, 6)), "=", v};
         6: return {"nonc=", v};
         default: return {"opaque=", v};
      endcase
   endfunction

   function automatic string rand_header();
      string s;
      int n;
      s = "Digest ";
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         s = {s, rand_token()};
         if (i != n - 1) s = {s, ($urandom_range(1) ? ", " : ",")};
      end
      return s;
   endfunction

   task automatic send_noise(int n);
      for (int i = 0; i < n; i++)
         send_byte(8'($urandom_range(255)), i == n - 1);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else rsp_ready <= !idle_on || $urandom_range(99) >= 33;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            result_type e;
            e = expected_q.pop_front();
            if (e !== got) begin
               $display("%0t: mismatch expected %p actual %p", $time, e, got);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send_header("Digest nonce=\"abc\", realm=\"r\", qop=\"auth,auth-int\"");
      send_header("Digest realm=plain,opaque=,algorithm=MD5-sess");
      send_header("Digest nonce=\"unterminated");
      send_header("Digest qop=\"auth-int\",algorithm=\"MD5\"");
      send_header("Digest noequals here, nonce=x");
      send_header("Dig");
      send_header("D");
      send_header("Digest nonce=\"q\"");
      send_header("Digest a=1,b=2,c=3,d=4,e=5,f=6,g=7,h=8,i=9,j=10,k=11,l=12,nonce=z");
      send_header("Digest qop=auth,auth,auth-int");
      send_part("Digest nonce=ab", 1'b0);
      send_byte(8'h00, 1'b0);
      send_header("realm=x");
      send_header("Digest nonce=\"\",opaque=\"\"");
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   task automatic test_long_header();
      string s;
      s = "Digest realm=";
      for (int i = 0; i < 1030; i++) send_byte(i < s.len() ? s[i] : "b", i == 1029);
   endtask

   task automatic test_random();
      int i;
      i = 0;
      while (i < 30) begin
         if (i >= 10 && i < 20) idle_on = 1'b0;
         else idle_on = 1'b1;
         if ($urandom_range(9) == 0) send_noise($urandom_range(1, 20));
         else send_header(rand_header());
         i++;
      end
      idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      for (int i = 0; i < 10; i++) send_header("Digest qop=auth");
   endtask

   initial begin
      parser_clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_long_header();
      test_backpressure();
      test_random();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) $display("tb_digest_auth_header_parser OK");
      else $display("tb_digest_auth_header_parser NOT OK");
      $finish;
   end

   initial begin
      #50ms;
      $display("tb_digest_auth_header_parser NOT OK");
      $finish;
   end

endmodule
